/* src/udec_pkg.sv */
package udec_pkg;

    // Largest Unicode scalar value, the surrogate range and the least code point per sequence length.
    localparam logic [20:0] MAX_CP        = 21'h10FFFF;
    localparam logic [20:0] SURR_LO       = 21'h00D800;
    localparam logic [20:0] SURR_HI       = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_LEN2   = 21'h000080;
    localparam logic [20:0] MIN_CP_LEN3   = 21'h000800;
    localparam logic [20:0] MIN_CP_LEN4   = 21'h010000;

    // Lead and continuation byte patterns.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // Buffer depth and the width of the byte count.
    localparam int BUF_DEPTH = 4;
    localparam int CNT_W     = 3;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // write the accepted byte into the buffer
        logic step;   // retire one decode step into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;      // the step at the buffer front produces a result
        logic last;      // that result is the last one for the current byte
        logic out_free;  // the output register can take a result this cycle
    } t_status;

    // Sequence length given by a lead byte; zero marks a bad lead.
    function automatic logic [CNT_W-1:0] seq_len(input logic [7:0] lead);
        logic [CNT_W-1:0] len;
        len = '0;
        if (!lead[7]) begin
            len = CNT_W'(1);
        end else if ((lead & LEAD2_MASK) == LEAD2_PAT) begin
            len = CNT_W'(2);
        end else if ((lead & LEAD3_MASK) == LEAD3_PAT) begin
            len = CNT_W'(3);
        end else if ((lead & LEAD4_MASK) == LEAD4_PAT) begin
            len = CNT_W'(4);
        end
        return len;
    endfunction

endpackage

/* src/utf8_stream_decoder.sv */
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_byte_value, i_final_byte
// output    out        o_out_valid / i_out_stall o_code_point, o_valid_res, o_run_end
//
// A byte is loaded into the buffer in ST_IDLE; ST_EVAL then retires each result it causes,
// or returns to ST_IDLE when the byte causes none.
// The controller steps the decoder once per result through a single output register.
// Reset is synchronous and active low; it empties the buffer and the output register.
// A stalled output holds the decode step; input is stalled until the byte is done.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic        o_valid_res,
    output logic        o_run_end
);
    import udec_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller.
    udec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath.
    udec_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_point (o_code_point),
        .o_valid_res  (o_valid_res),
        .o_run_end    (o_run_end)
    );

endmodule

/* src/udec_ctrl.sv */
module udec_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  udec_pkg::t_status i_status,
    output udec_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import udec_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_status.emit) begin
                    // Nothing more to decode until the next byte arrives.
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/udec_dp.sv */
module udec_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  udec_pkg::t_cmd    i_cmd,
    output udec_pkg::t_status o_status,
    input  logic [7:0]        i_byte_value,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [20:0]       o_code_point,
    output logic              o_valid_res,
    output logic              o_run_end
);
    import udec_pkg::*;

    logic [7:0]       r_buf [BUF_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic             r_fin;
    logic             r_out_valid;
    logic [20:0]      r_code_point;
    logic             r_valid_res;
    logic             r_run_end;

    logic [7:0]       lead;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] drop;
    logic [CNT_W-1:0] remain;
    logic [20:0]      cp2;
    logic [20:0]      cp3;
    logic [20:0]      cp4;
    logic [20:0]      cp;
    logic             cont_ok;
    logic             range_ok;
    logic             emit;
    logic             good;
    logic             next_emits;
    logic [7:0]       nb [BUF_DEPTH];

    // Decode one step at the front of the buffer.
    always_comb begin
        lead = r_buf[0];
        len  = seq_len(lead);
        cp2  = {10'd0, lead[4:0], r_buf[1][5:0]};
        cp3  = {5'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
        cp4  = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
        cp       = {13'd0, lead};
        cont_ok  = 1'b1;
        range_ok = 1'b1;
        case (len)
            CNT_W'(2): begin
                cp       = cp2;
                cont_ok  = (r_buf[1] & CONT_MASK) == CONT_PAT;
                range_ok = cp2 >= MIN_CP_LEN2;
            end
            CNT_W'(3): begin
                cp       = cp3;
                cont_ok  = ((r_buf[1] & CONT_MASK) == CONT_PAT)
                        && ((r_buf[2] & CONT_MASK) == CONT_PAT);
                range_ok = (cp3 >= MIN_CP_LEN3)
                        && !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
            end
            CNT_W'(4): begin
                cp       = cp4;
                cont_ok  = ((r_buf[1] & CONT_MASK) == CONT_PAT)
                        && ((r_buf[2] & CONT_MASK) == CONT_PAT)
                        && ((r_buf[3] & CONT_MASK) == CONT_PAT);
                range_ok = (cp4 >= MIN_CP_LEN4) && (cp4 <= MAX_CP);
            end
            default: begin
                cp = {13'd0, lead};
            end
        endcase

        // Outcome of the step and how many bytes it consumes.
        good = 1'b0;
        emit = 1'b0;
        drop = '0;
        if (r_cnt == '0) begin
            emit = 1'b0;
        end else if (len == '0) begin
            emit = 1'b1;
            drop = CNT_W'(1);
        end else if (r_cnt < len) begin
            // A cut-short sequence is flushed whole at the end of the string.
            emit = r_fin;
            drop = r_cnt;
        end else begin
            emit = 1'b1;
            good = cont_ok && range_ok;
            drop = good ? len : CNT_W'(1);
        end
        remain = r_cnt - drop;
    end

    // Buffer after the drop and a look ahead at the following step.
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            if (i + int'(drop) < BUF_DEPTH) begin
                nb[i] = r_buf[2'(i + int'(drop))];
            end else begin
                nb[i] = r_buf[i];
            end
        end
        len_next   = seq_len(nb[0]);
        next_emits = (remain != '0)
                  && !((len_next != '0) && (remain < len_next) && !r_fin);
    end

    assign o_status.emit     = emit;
    assign o_status.last     = !next_emits;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Pending byte buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf[r_cnt[1:0]] <= i_byte_value;
            r_fin             <= i_final_byte;
        end else if (i_cmd.step) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                r_buf[i] <= nb[i];
            end
        end
    end

    // Byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.step) begin
            r_cnt <= remain;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_code_point <= good ? cp : '0;
            r_valid_res  <= good;
            r_run_end    <= !next_emits;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_valid_res  = r_valid_res;
    assign o_run_end    = r_run_end;

endmodule

/* src/udec_checker.sv */
module udec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [20:0] o_code_point,
    input logic        o_valid_res,
    input logic        o_run_end
);
    import udec_pkg::*;

    // A stalled result transfer holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_code_point)
            && $stable(o_valid_res) && $stable(o_run_end))
        else $error("stalled result changed");

    // An error mark carries a zero code point.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_code_point == '0)
        else $error("error mark with nonzero code point");

    // A decoded code point is a Unicode scalar value.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> (o_code_point <= MAX_CP)
            && ((o_code_point < SURR_LO) || (o_code_point > SURR_HI)))
        else $error("decoded value is not a scalar value");

    // The decoder stalls input in the cycle after a byte transfer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("byte accepted in back-to-back cycles");

endmodule

bind utf8_stream_decoder udec_checker u_udec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_code_point (o_code_point),
    .o_valid_res  (o_valid_res),
    .o_run_end    (o_run_end)
);
